FILE: rtl/core/scc_pkg.sv
// Shared constants, types and state encoding of the smoothness cost accumulator.
`timescale 1ns / 1ps

package scc_pkg;

  localparam int unsigned TapsDef        = 7;
  localparam int unsigned MaxRowLenDef   = 1024;
  localparam int unsigned SampleWidthDef = 32;

  localparam int unsigned POS_W  = 32;
  localparam int unsigned TAP_W  = 8;
  localparam int unsigned COEF_W = 56;
  localparam int unsigned GAIN_W = 32;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned SQ_W   = 63;
  localparam int unsigned COST_W = 64;
  localparam int unsigned APB_DW = 64;
  localparam int unsigned APB_AW = 6;
  localparam int unsigned REG_W  = 3;

  localparam logic [COEF_W-1:0] CoefRst   = '0;
  localparam logic [GAIN_W-1:0] GainRst   = GAIN_W'(65536);
  localparam logic [LEN_W-1:0]  RowLenRst = LEN_W'(64);
  localparam logic [LEN_W-1:0]  SkipLRst  = LEN_W'(10);
  localparam logic [LEN_W-1:0]  SkipRRst  = LEN_W'(10);

  typedef enum logic [REG_W-1:0] {
    REG_COEF,
    REG_GAIN,
    REG_ROW_LEN,
    REG_SKIP_L,
    REG_SKIP_R
  } scc_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_SUM,
    S_MAG,
    S_MUL,
    S_RND,
    S_SQR,
    S_FIN
  } scc_state_e;

  typedef struct packed {
    logic [COEF_W-1:0] coef;
    logic [GAIN_W-1:0] gain;
    logic [LEN_W-1:0]  row_len;
    logic [LEN_W-1:0]  skip_l;
    logic [LEN_W-1:0]  skip_r;
  } scc_cfg_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic clear;
  } scc_cell_ctl_t;

  typedef struct packed {
    logic mag_en;
    logic mul_en;
    logic rnd_en;
    logic sq_en;
  } scc_scale_ctl_t;

endpackage

FILE: rtl/core/scc_if.sv
// Valid/ready channel interfaces for input samples and result words.
`timescale 1ns / 1ps

interface scc_in_if;
  import scc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] position;
  logic                    clear_total;

  modport source (output valid, output position, output clear_total, input ready);
  modport sink   (input valid, input position, input clear_total, output ready);
endinterface

interface scc_out_if;
  import scc_pkg::*;

  logic              valid;
  logic              ready;
  logic [SQ_W-1:0]   squared_value;
  logic              squared_valid;
  logic              in_inner;
  logic              row_done;
  logic [COST_W-1:0] row_cost;
  logic [COST_W-1:0] total_cost;

  modport source (output valid, output squared_value, output squared_valid,
                  output in_inner, output row_done, output row_cost,
                  output total_cost, input ready);
  modport sink   (input valid, input squared_value, input squared_valid,
                  input in_inner, input row_done, input row_cost,
                  input total_cost, output ready);
endinterface

FILE: rtl/core/smoothness_cost_accumulator.sv
// Top level: row sequencer, tap cell chain, scaling unit, cost accumulators and APB port.
// A new input word is taken only in the idle state, after the last word has passed the
// partial-sum ripple through the tap cell chain and the scaling steps; a result that the
// sink has not taken stalls the finish step. The result word is registered in the finish
// step, and the next input word is taken while that result still waits for the sink.
// Reset clears the sample window, row index and both cost totals and restores the
// register defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module smoothness_cost_accumulator #(
  parameter int unsigned TAPS           = scc_pkg::TapsDef,
  parameter int unsigned MAX_ROW_LENGTH = scc_pkg::MaxRowLenDef,
  parameter int unsigned SAMPLE_WIDTH   = scc_pkg::SampleWidthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  scc_in_if.sink                     in_ch,
  scc_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [scc_pkg::APB_AW-1:0] paddr,
  input  logic [scc_pkg::APB_DW-1:0] pwdata,
  output logic [scc_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import scc_pkg::*;

  localparam int unsigned Half  = TAPS / 2;
  localparam int unsigned NCell = 2 * Half + 1;
  localparam int unsigned SumW  = SAMPLE_WIDTH + TAP_W + $clog2(NCell);
  localparam int unsigned CntW  = $clog2(NCell);
  localparam int unsigned IdxW  = LEN_W + 2;

  scc_cfg_t       cfg;
  scc_state_e     state_q, state_d;
  scc_cell_ctl_t  cell_ctl;
  scc_scale_ctl_t scale_ctl;
  logic           fin_go;
  logic           accept;

  logic [CntW-1:0]  cnt_q;
  logic [LEN_W-1:0] idx_q;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] right;
  logic [IdxW-1:0]  centre;
  logic             done_d, has_centre_d, inner_d;
  logic             done_q, has_centre_q, inner_q, clear_q;

  logic signed [SAMPLE_WIDTH-1:0] smp_chain [NCell+1];
  logic signed [SumW-1:0]         sum_chain [NCell+1];
  logic [SQ_W-1:0]                sq_raw;
  logic [SQ_W-1:0]                sq_val;

  logic [COST_W-1:0] row_q, tot_q;
  logic [COST_W-1:0] row_sum, tot_base, tot_sum;
  logic [COST_W:0]   row_add, tot_add;

  logic              ovalid_q;
  logic [SQ_W-1:0]   osq_q;
  logic              ovld_q, oinner_q, odone_q;
  logic [COST_W-1:0] orow_q, otot_q;

  scc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign accept = in_ch.valid && in_ch.ready;

  // Row bookkeeping for the word being taken.
  always_comb begin
    if (cfg.row_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(cfg.row_len) > 32'(MAX_ROW_LENGTH)) begin
      len_eff = LEN_W'(MAX_ROW_LENGTH);
    end else begin
      len_eff = cfg.row_len;
    end
    right        = (cfg.skip_r < LEN_W'(Half)) ? LEN_W'(Half) : cfg.skip_r;
    done_d       = ({1'b0, idx_q} + (LEN_W + 1)'(1)) >= {1'b0, len_eff};
    has_centre_d = idx_q >= LEN_W'(Half);
    centre       = IdxW'(idx_q) - IdxW'(Half);
    inner_d      = has_centre_d && (centre >= IdxW'(cfg.skip_l))
                   && ((centre + IdxW'(right)) < IdxW'(len_eff));
  end

  // Tap cell chain; the newest sample enters at the top cell.
  assign smp_chain[NCell] = in_ch.position[SAMPLE_WIDTH-1:0];
  assign sum_chain[0]     = '0;

  for (genvar gk = 0; gk < NCell; gk++) begin : g_cell
    scc_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .SUM_W        (SumW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (cell_ctl),
      .sample_i (smp_chain[gk+1]),
      .tap_i    (cfg.coef[TAP_W*gk +: TAP_W]),
      .sum_i    (sum_chain[gk]),
      .sample_o (smp_chain[gk]),
      .sum_o    (sum_chain[gk+1])
    );
  end

  scc_scale #(
    .F_W (SumW)
  ) u_scale (
    .clk_i  (clk_i),
    .ctl_i  (scale_ctl),
    .f_i    (sum_chain[NCell]),
    .gain_i (cfg.gain),
    .sq_o   (sq_raw)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_PROD;
      end
      S_PROD: state_d = S_SUM;
      S_SUM: begin
        if (cnt_q == CntW'(NCell - 1)) state_d = S_MAG;
      end
      S_MAG: state_d = S_MUL;
      S_MUL: state_d = S_RND;
      S_RND: state_d = S_SQR;
      S_SQR: state_d = S_FIN;
      S_FIN: begin
        if (!ovalid_q || out_ch.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ch.ready       = 1'b0;
    cell_ctl          = '0;
    scale_ctl         = '0;
    fin_go            = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ch.ready   = 1'b1;
        cell_ctl.load = in_ch.valid;
      end
      S_PROD: begin
        cell_ctl.capture = 1'b1;
        cell_ctl.clear   = done_q;
      end
      S_SUM: begin
      end
      S_MAG: scale_ctl.mag_en = 1'b1;
      S_MUL: scale_ctl.mul_en = 1'b1;
      S_RND: scale_ctl.rnd_en = 1'b1;
      S_SQR: scale_ctl.sq_en  = 1'b1;
      S_FIN: fin_go = !ovalid_q || out_ch.ready;
      default: begin
      end
    endcase
  end

  // Saturating cost sums.
  always_comb begin
    sq_val   = has_centre_q ? sq_raw : '0;
    row_add  = (COST_W + 1)'(row_q) + (COST_W + 1)'(sq_val);
    tot_base = clear_q ? '0 : tot_q;
    tot_add  = (COST_W + 1)'(tot_base) + (COST_W + 1)'(sq_val);
    row_sum  = row_q;
    tot_sum  = tot_base;
    if (inner_q) begin
      row_sum = row_add[COST_W] ? '1 : row_add[COST_W-1:0];
      tot_sum = tot_add[COST_W] ? '1 : tot_add[COST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      row_q    <= '0;
      tot_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_PROD) begin
        cnt_q <= '0;
      end else if (state_q == S_SUM) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (accept) begin
        idx_q <= done_d ? '0 : idx_q + LEN_W'(1);
      end
      if (fin_go) begin
        row_q    <= done_q ? '0 : row_sum;
        tot_q    <= tot_sum;
        ovalid_q <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      done_q       <= done_d;
      has_centre_q <= has_centre_d;
      inner_q      <= inner_d;
      clear_q      <= in_ch.clear_total;
    end
    if (fin_go) begin
      osq_q    <= sq_val;
      ovld_q   <= has_centre_q;
      oinner_q <= inner_q;
      odone_q  <= done_q;
      orow_q   <= row_sum;
      otot_q   <= tot_sum;
    end
  end

  assign out_ch.valid         = ovalid_q;
  assign out_ch.squared_value = osq_q;
  assign out_ch.squared_valid = ovld_q;
  assign out_ch.in_inner      = oinner_q;
  assign out_ch.row_done      = odone_q;
  assign out_ch.row_cost      = orow_q;
  assign out_ch.total_cost    = otot_q;

endmodule

FILE: rtl/core/scc_regs.sv
// APB configuration register file of the smoothness cost accumulator.
`timescale 1ns / 1ps

module scc_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [scc_pkg::APB_AW-1:0] paddr,
  input  logic [scc_pkg::APB_DW-1:0] pwdata,
  output logic [scc_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output scc_pkg::scc_cfg_t         cfg_o
);
  import scc_pkg::*;

  scc_cfg_t cfg_q;
  scc_reg_e sel;
  logic     wr_en;

  assign sel    = scc_reg_e'(paddr[APB_AW-1:APB_AW-REG_W]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef    <= CoefRst;
      cfg_q.gain    <= GainRst;
      cfg_q.row_len <= RowLenRst;
      cfg_q.skip_l  <= SkipLRst;
      cfg_q.skip_r  <= SkipRRst;
    end else if (wr_en) begin
      unique case (sel)
        REG_COEF:    cfg_q.coef    <= pwdata[COEF_W-1:0];
        REG_GAIN:    cfg_q.gain    <= pwdata[GAIN_W-1:0];
        REG_ROW_LEN: cfg_q.row_len <= pwdata[LEN_W-1:0];
        REG_SKIP_L:  cfg_q.skip_l  <= pwdata[LEN_W-1:0];
        REG_SKIP_R:  cfg_q.skip_r  <= pwdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_COEF:    prdata = APB_DW'(cfg_q.coef);
      REG_GAIN:    prdata = APB_DW'(cfg_q.gain);
      REG_ROW_LEN: prdata = APB_DW'(cfg_q.row_len);
      REG_SKIP_L:  prdata = APB_DW'(cfg_q.skip_l);
      REG_SKIP_R:  prdata = APB_DW'(cfg_q.skip_r);
      default:     prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/scc_cell.sv
// One tap cell: holds a window sample, forms its product and passes a partial sum on.
`timescale 1ns / 1ps

module scc_cell #(
  parameter int unsigned SAMPLE_WIDTH = scc_pkg::SampleWidthDef,
  parameter int unsigned SUM_W        = SAMPLE_WIDTH + scc_pkg::TAP_W + 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  scc_pkg::scc_cell_ctl_t         ctl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic signed [scc_pkg::TAP_W-1:0] tap_i,
  input  logic signed [SUM_W-1:0]        sum_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_o,
  output logic signed [SUM_W-1:0]        sum_o
);
  import scc_pkg::*;

  localparam int unsigned ProdW = SAMPLE_WIDTH + TAP_W;

  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic signed [ProdW-1:0]        prod_q;
  logic signed [SUM_W-1:0]        sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (ctl_i.clear) begin
      sample_q <= '0;
    end else if (ctl_i.load) begin
      sample_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      prod_q <= ProdW'(sample_q) * ProdW'(tap_i);
    end
    sum_q <= sum_i + SUM_W'(prod_q);
  end

  assign sample_o = sample_q;
  assign sum_o    = sum_q;

endmodule

FILE: rtl/core/scc_scale.sv
// Q16.16 gain multiply, round half away from zero, 32-bit signed saturation and squaring.
`timescale 1ns / 1ps

module scc_scale #(
  parameter int unsigned F_W = 43
) (
  input  logic                              clk_i,
  input  scc_pkg::scc_scale_ctl_t           ctl_i,
  input  logic signed [F_W-1:0]             f_i,
  input  logic [scc_pkg::GAIN_W-1:0]        gain_i,
  output logic [scc_pkg::SQ_W-1:0]          sq_o
);
  import scc_pkg::*;

  localparam int unsigned HalfG = GAIN_W / 2;
  localparam int unsigned MulW  = F_W + HalfG;
  localparam int unsigned PW    = F_W + HalfG + 1;

  logic             neg_q, neg2_q;
  logic [F_W-1:0]   mag_q;
  logic [MulW-1:0]  hi_q, lo_q;
  logic [31:0]      r_q;
  logic [63:0]      sq_q;
  logic [PW-1:0]    p_sum;
  logic [PW-1:0]    p_rnd;
  logic [31:0]      lim;
  logic [31:0]      r_d;

  always_comb begin
    lim   = neg2_q ? 32'h8000_0000 : 32'h7fff_ffff;
    p_sum = (PW'(hi_q) << HalfG) + PW'(lo_q);
    p_rnd = (p_sum + PW'(1 << (HalfG - 1))) >> HalfG;
    if (|hi_q[MulW-1:31]) begin
      r_d = lim;
    end else if (64'(p_rnd) > 64'(lim)) begin
      r_d = lim;
    end else begin
      r_d = 32'(p_rnd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mag_en) begin
      neg_q <= f_i[F_W-1];
      mag_q <= f_i[F_W-1] ? F_W'(-f_i) : F_W'(f_i);
    end
    if (ctl_i.mul_en) begin
      neg2_q <= neg_q;
      hi_q   <= MulW'(mag_q) * MulW'(gain_i[GAIN_W-1:HalfG]);
      lo_q   <= MulW'(mag_q) * MulW'(gain_i[HalfG-1:0]);
    end
    if (ctl_i.rnd_en) begin
      r_q <= r_d;
    end
    if (ctl_i.sq_en) begin
      sq_q <= 64'(r_q) * 64'(r_q);
    end
  end

  assign sq_o = sq_q[SQ_W-1:0];

endmodule

FILE: tb/tb_smoothness_cost_accumulator.sv
// Testbench: directed and random sample rows, each result word checked against a predictor.
`timescale 1ns / 1ps

module tb_smoothness_cost_accumulator;
  import scc_pkg::*;

  localparam int unsigned HalfTaps     = TapsDef / 2;
  localparam int unsigned WinDepth     = 2 * HalfTaps;
  localparam int unsigned SettleCycles = 2 * HalfTaps + 12;
  localparam int unsigned RegSlots     = (1 << APB_AW) / 8;
  localparam int unsigned IdlePercent  = 9;
  localparam int unsigned MaxGap       = 2 * HalfTaps + 10;

  localparam logic [POS_W-1:0] EDGE_POS [8] = '{
    32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
    32'h0000_0001, 32'h0001_0000, 32'hfffe_0000, 32'h8000_0001
  };

  typedef struct packed {
    logic [SQ_W-1:0]   squared_value;
    logic              squared_valid;
    logic              in_inner;
    logic              row_done;
    logic [COST_W-1:0] row_cost;
    logic [COST_W-1:0] total_cost;
  } cost_word_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  scc_in_if  sample_bus ();
  scc_out_if cost_bus ();

  smoothness_cost_accumulator DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (sample_bus),
    .out_ch  (cost_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [COEF_W-1:0]       cfg_coef;
  logic [GAIN_W-1:0]       cfg_gain;
  logic [LEN_W-1:0]        cfg_row_len;
  logic [LEN_W-1:0]        cfg_skip_l;
  logic [LEN_W-1:0]        cfg_skip_r;
  logic signed [POS_W-1:0] hist [WinDepth];
  logic [LEN_W-1:0]        row_index;
  logic [COST_W-1:0]       row_sum;
  logic [COST_W-1:0]       total_sum;

  cost_word_t              pending_costs [$];
  int unsigned             error_count = 0;
  bit                      src_idle_en = 1'b1;
  bit                      sink_idle_en = 1'b1;
  int unsigned             hold_request = 0;
  logic signed [POS_W-1:0] ramp_pos = '0;
  logic signed [POS_W-1:0] ramp_step = 32'sd4096;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic void reset_model();
    cfg_coef    = CoefRst;
    cfg_gain    = GainRst;
    cfg_row_len = RowLenRst;
    cfg_skip_l  = SkipLRst;
    cfg_skip_r  = SkipRRst;
    foreach (hist[i]) hist[i] = '0;
    row_index = '0;
    row_sum   = '0;
    total_sum = '0;
  endfunction

  function automatic logic [APB_DW-1:0] reg_value(int unsigned index);
    case (index)
      int'(REG_COEF):    return APB_DW'(cfg_coef);
      int'(REG_GAIN):    return APB_DW'(cfg_gain);
      int'(REG_ROW_LEN): return APB_DW'(cfg_row_len);
      int'(REG_SKIP_L):  return APB_DW'(cfg_skip_l);
      int'(REG_SKIP_R):  return APB_DW'(cfg_skip_r);
      default:           return '0;
    endcase
  endfunction

  function automatic logic [COST_W-1:0] sat_add(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? '1 : s[COST_W-1:0];
  endfunction

  // Rounded and saturated magnitude of the filtered value times the Q16.16 gain.
  function automatic longint unsigned scaled_magnitude(longint f);
    longint unsigned m, lim, hi, lo, p, r;
    m   = (f < 0) ? longint'(-f) : longint'(f);
    lim = (f < 0) ? 64'h8000_0000 : 64'h7fff_ffff;
    hi  = m * longint'(cfg_gain[GAIN_W-1:16]);
    lo  = m * longint'(cfg_gain[15:0]);
    if (hi >= 64'h8000_0000) return lim;
    p = (hi << 16) + lo;
    r = (p + 64'h8000) >> 16;
    return (r > lim) ? lim : r;
  endfunction

  function automatic cost_word_t predict_cost_word(logic signed [POS_W-1:0] x, logic clr);
    cost_word_t              w;
    longint unsigned         len, right, centre, mag, sq;
    longint                  f;
    logic signed [TAP_W-1:0] tap;
    logic signed [POS_W-1:0] s;
    w = '0;
    len = longint'(cfg_row_len);
    if (len == 0) len = 1;
    else if (len > MaxRowLenDef) len = MaxRowLenDef;
    right = (cfg_skip_r < HalfTaps) ? HalfTaps : longint'(cfg_skip_r);
    w.row_done = (longint'(row_index) + 1 >= len);
    if (clr) total_sum = '0;
    if (row_index >= HalfTaps) begin
      centre = longint'(row_index) - HalfTaps;
      f = 0;
      for (int k = 0; k <= WinDepth; k++) begin
        tap = cfg_coef[TAP_W*k +: TAP_W];
        if (k == WinDepth) s = x;
        else s = hist[WinDepth-1-k];
        f += longint'(s) * longint'(tap);
      end
      mag = scaled_magnitude(f);
      sq  = mag * mag;
      w.squared_value = sq[SQ_W-1:0];
      w.squared_valid = 1'b1;
      w.in_inner = (centre >= longint'(cfg_skip_l)) && (centre + right < len);
      if (w.in_inner) begin
        row_sum   = sat_add(row_sum, sq);
        total_sum = sat_add(total_sum, sq);
      end
    end
    w.row_cost   = row_sum;
    w.total_cost = total_sum;
    if (w.row_done) begin
      foreach (hist[i]) hist[i] = '0;
      row_index = '0;
      row_sum   = '0;
    end else begin
      for (int i = WinDepth - 1; i > 0; i--) hist[i] = hist[i-1];
      hist[0] = x;
      row_index = row_index + 1'b1;
    end
    return w;
  endfunction

  function automatic logic [POS_W-1:0] gen_position();
    case ($urandom_range(4))
      0, 1: return $urandom;
      2: return POS_W'($urandom_range(0, 1 << 20)) - POS_W'(1 << 19);
      3: return EDGE_POS[$urandom_range(7)];
      default: begin
        ramp_pos += ramp_step;
        if ($urandom_range(15) == 0)
          ramp_step = POS_W'($urandom_range(0, 1 << 16)) - POS_W'(1 << 15);
        return ramp_pos;
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [COST_W-1:0] want,
                                      logic [COST_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  task automatic check_reg(int unsigned index);
    logic [APB_DW-1:0] data;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_AW'(index * 8);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (data !== reg_value(index)) begin
      $error("register %0d mismatch: expected %0h, actual %0h", index, reg_value(index), data);
      error_count++;
    end
  endtask

  task automatic write_reg(int unsigned index, logic [APB_DW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(index * 8);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (index)
      int'(REG_COEF):    cfg_coef    = value[COEF_W-1:0];
      int'(REG_GAIN):    cfg_gain    = value[GAIN_W-1:0];
      int'(REG_ROW_LEN): cfg_row_len = value[LEN_W-1:0];
      int'(REG_SKIP_L):  cfg_skip_l  = value[LEN_W-1:0];
      int'(REG_SKIP_R):  cfg_skip_r  = value[LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (index <= int'(REG_SKIP_R)) check_reg(index);
  endtask

  task automatic send_sample(logic signed [POS_W-1:0] pos, logic clr);
    cost_word_t w;
    @(negedge clk_i);
    if (src_idle_en && $urandom_range(99) < IdlePercent) begin
      sample_bus.valid <= 1'b0;
      repeat ($urandom_range(1, MaxGap)) @(negedge clk_i);
    end
    sample_bus.valid       <= 1'b1;
    sample_bus.position    <= pos;
    sample_bus.clear_total <= clr;
    do @(posedge clk_i); while (!sample_bus.ready);
    w = predict_cost_word(pos, clr);
    pending_costs.push_back(w);
  endtask

  task automatic drain_costs();
    @(negedge clk_i);
    sample_bus.valid <= 1'b0;
    while (pending_costs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic randomize_settings();
    logic [APB_DW-1:0] coef;
    logic [GAIN_W-1:0] gain;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  skip [2];
    coef = '0;
    case ($urandom_range(3))
      0: coef = {$urandom, $urandom};
      1: for (int k = 0; k < TapsDef; k++)
           coef[TAP_W*k +: TAP_W] = TAP_W'($urandom_range(0, 8)) - TAP_W'(4);
      2: for (int k = 0; k < TapsDef; k++)
           case ($urandom_range(3))
             0: coef[TAP_W*k +: TAP_W] = 8'h7f;
             1: coef[TAP_W*k +: TAP_W] = 8'h80;
             2: coef[TAP_W*k +: TAP_W] = 8'hff;
             default: coef[TAP_W*k +: TAP_W] = 8'h00;
           endcase
      default: for (int k = 0; k < TapsDef; k++)
                 coef[TAP_W*k +: TAP_W] = $urandom_range(1) ? TAP_W'($urandom) : 8'h00;
    endcase
    case ($urandom_range(4))
      0: gain = $urandom;
      1: gain = GAIN_W'($urandom_range(0, 4 * 65536));
      2: gain = '0;
      3: gain = '1;
      default: gain = GainRst;
    endcase
    case ($urandom_range(9))
      0: len = '0;
      1: len = LEN_W'($urandom_range(1, 4));
      2: len = '1;
      3: len = LEN_W'($urandom_range(41, 300));
      default: len = LEN_W'($urandom_range(5, 40));
    endcase
    foreach (skip[i])
      case ($urandom_range(5))
        0: skip[i] = '0;
        1: skip[i] = '1;
        2: skip[i] = LEN_W'(MaxRowLenDef);
        default: skip[i] = LEN_W'($urandom_range(0, 16));
      endcase
    write_reg(REG_COEF, coef);
    write_reg(REG_GAIN, {$urandom, gain});
    write_reg(REG_ROW_LEN, {$urandom, 21'($urandom), len});
    write_reg(REG_SKIP_L, {$urandom, 21'($urandom), skip[0]});
    write_reg(REG_SKIP_R, {$urandom, 21'($urandom), skip[1]});
    if ($urandom_range(2) == 0)
      write_reg($urandom_range(int'(REG_SKIP_R) + 1, RegSlots - 1), {$urandom, $urandom});
  endtask

  task automatic test_register_defaults();
    for (int i = 0; i <= int'(REG_SKIP_R); i++) check_reg(i);
  endtask

  task automatic test_second_difference();
    write_reg(REG_ROW_LEN, 64'd8);
    write_reg(REG_SKIP_L, 64'd0);
    write_reg(REG_SKIP_R, 64'd0);
    write_reg(REG_GAIN, 64'd65536);
    write_reg(REG_COEF, 64'h0000_0001_fe01_0000);
    for (int i = 0; i < 8; i++) send_sample(EDGE_POS[i], i == 5);
    drain_costs();
  endtask

  task automatic test_saturation();
    write_reg(REG_COEF, 64'h007f_807f_807f_807f);
    write_reg(REG_GAIN, 64'hffff_ffff);
    for (int i = 0; i < 8; i++) send_sample(i[0] ? 32'h8000_0000 : 32'h7fff_ffff, i == 0);
    drain_costs();
  endtask

  task automatic test_short_rows();
    write_reg(REG_ROW_LEN, 64'd0);
    for (int i = 0; i < 3; i++) send_sample(gen_position(), 1'b0);
    drain_costs();
  endtask

  task automatic test_row_shortened();
    write_reg(REG_ROW_LEN, 64'd12);
    for (int i = 0; i < 5; i++) send_sample(gen_position(), 1'b0);
    drain_costs();
    write_reg(REG_ROW_LEN, 64'd3);
    for (int i = 0; i < 2; i++) send_sample(gen_position(), 1'b1);
    drain_costs();
  endtask

  task automatic test_random_rows();
    int unsigned n;
    for (int phase = 0; phase < 10; phase++) begin
      randomize_settings();
      src_idle_en  = (phase != 4);
      sink_idle_en = (phase != 4);
      n = (phase == 4) ? 120 : 45;
      for (int i = 0; i < n; i++) send_sample(gen_position(), $urandom_range(99) < 4);
      drain_costs();
    end
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    randomize_settings();
    write_reg(REG_ROW_LEN, 64'd16);
    src_idle_en  = 1'b0;
    hold_request = 400;
    for (int i = 0; i < 40; i++) send_sample(gen_position(), $urandom_range(99) < 4);
    drain_costs();
    src_idle_en = 1'b1;
  endtask

  task automatic test_long_row();
    write_reg(REG_ROW_LEN, 64'd2047);
    write_reg(REG_SKIP_L, 64'd3);
    write_reg(REG_SKIP_R, 64'd3);
    write_reg(REG_COEF, 64'h0000_01fc_06fc_0100);
    write_reg(REG_GAIN, 64'($urandom_range(0, 8 * 65536)));
    for (int i = 0; i < MaxRowLenDef + 2; i++)
      send_sample(gen_position(), $urandom_range(199) == 0);
    drain_costs();
  endtask

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    cost_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        cost_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        cost_bus.ready <= !(sink_idle_en && $urandom_range(99) < IdlePercent);
      end
    end
  end

  always @(posedge clk_i) begin
    cost_word_t want;
    if (rst_ni && cost_bus.valid && cost_bus.ready) begin
      if (pending_costs.size() == 0) begin
        $error("result word arrived with no expected word waiting");
        error_count++;
      end else begin
        want = pending_costs.pop_front();
        check_field("squared_value", COST_W'(want.squared_value), COST_W'(cost_bus.squared_value));
        check_field("squared_valid", COST_W'(want.squared_valid), COST_W'(cost_bus.squared_valid));
        check_field("in_inner", COST_W'(want.in_inner), COST_W'(cost_bus.in_inner));
        check_field("row_done", COST_W'(want.row_done), COST_W'(cost_bus.row_done));
        check_field("row_cost", want.row_cost, cost_bus.row_cost);
        check_field("total_cost", want.total_cost, cost_bus.total_cost);
      end
    end
  end

  initial begin
    rst_ni                 = 1'b0;
    sample_bus.valid       = 1'b0;
    sample_bus.position    = '0;
    sample_bus.clear_total = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    reset_model();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_register_defaults();
    test_second_difference();
    test_saturation();
    test_short_rows();
    test_row_shortened();
    test_random_rows();
    test_backpressure();
    test_long_row();

    if (error_count == 0 && pending_costs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/scc_pkg.sv
rtl/core/scc_if.sv
rtl/core/scc_regs.sv
rtl/core/scc_cell.sv
rtl/core/scc_scale.sv
rtl/core/smoothness_cost_accumulator.sv
tb/tb_smoothness_cost_accumulator.sv
